// ===== sv/sld_pkg.sv =====
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants for the sequence loop detector.
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam int DEF_DATA_DEPTH = 4096;
  localparam int DEF_SONGS      = 16;
  localparam int DEF_TRACKS     = 16;
  localparam int DEF_MAX_STACK  = 8;
  localparam int DEF_ID_WIDTH   = 16;

  localparam logic signed [15:0] COUNT_MAX     = 16'sd32767;
  localparam logic signed [15:0] COUNT_STOPPED = -16'sd1;
  localparam logic signed [15:0] COUNT_SHARED  = -16'sd2;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_CHECK = 3'd2,
    CMD_JUMP  = 3'd3,
    CMD_PUSH  = 3'd4,
    CMD_POP   = 3'd5,
    CMD_GET   = 3'd6,
    CMD_RESET = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MOD,
    S_RD,
    S_JT,
    S_JR,
    S_JC,
    S_COUNT
  } state_t;

  // one classified command waiting in the queue
  typedef struct packed {
    cmd_t               cmd;
    logic [3:0]         track;
    logic               track_ok;
    logic signed [4:0]  parent;
    logic [3:0]         song;      // already reduced to a valid song index
    logic [11:0]        position;
    logic               skip;
  } sld_entry_t;

  typedef struct packed {
    logic       valid;
    sld_entry_t head;
  } sld_queue_t;

endpackage

// ===== sv/sld_front.sv =====
// ----------------------------------------------------------------------------
// sld_front
// Accepts commands, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sld_front #(
  parameter int SONGS  = sld_pkg::DEF_SONGS,
  parameter int TRACKS = sld_pkg::DEF_TRACKS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2:0]            cmd,
  input  logic [3:0]            track,
  input  logic signed [4:0]     parent,
  input  logic [3:0]            song,
  input  logic [11:0]           position,
  input  logic                  skip_check,
  input  logic                  clearing,
  input  logic                  pop,
  output logic                  busy,
  output sld_pkg::sld_queue_t   q
);

  sld_pkg::sld_entry_t ent [2];
  sld_pkg::sld_entry_t e_in;
  logic       wp, rp;
  logic [1:0] cnt;
  logic       acc;

  assign busy = (cnt == 2'd2) || clearing;
  assign acc  = start && !busy;

  always_comb begin
    e_in.cmd      = sld_pkg::cmd_t'(cmd);
    e_in.track    = track;
    e_in.track_ok = (32'(track) < TRACKS);
    e_in.parent   = parent;
    // 4-bit song index: the reduction is a small table
    e_in.song     = '0;
    for (int k = 0; k < 16; k++) begin
      if (song == 4'(k)) e_in.song = 4'(k % SONGS);
    end
    e_in.position = position;
    e_in.skip     = skip_check;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ent[wp] <= e_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (acc) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, acc} - {1'b0, pop};
    end
  end

  assign q.valid = (cnt != 2'd0);
  assign q.head  = ent[rp];

endmodule

// ===== sv/sld_back.sv =====
// ----------------------------------------------------------------------------
// sld_back
// Command sequencer: track/song tables, ID stacks, position tag memory.
// ----------------------------------------------------------------------------
module sld_back #(
  parameter int DATA_DEPTH = sld_pkg::DEF_DATA_DEPTH,
  parameter int SONGS      = sld_pkg::DEF_SONGS,
  parameter int TRACKS     = sld_pkg::DEF_TRACKS,
  parameter int MAX_STACK  = sld_pkg::DEF_MAX_STACK,
  parameter int ID_WIDTH   = sld_pkg::DEF_ID_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sld_pkg::sld_queue_t  q,
  output logic                 pop,
  output logic                 clearing,
  output logic signed [15:0]   loop_count,
  output logic                 done
);

  localparam int AW    = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int SW    = (SONGS > 1) ? $clog2(SONGS) : 1;
  localparam int TW    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int PW    = $clog2(TRACKS + 1);
  localparam int IW    = $clog2(TRACKS + 1);
  localparam int SLOTS = MAX_STACK + 1;
  localparam int NSLOT = SONGS * SLOTS;
  localparam int LW    = $clog2(NSLOT);
  localparam int DW    = $clog2(MAX_STACK + 1);

  function automatic logic [ID_WIDTH-1:0] issue(input logic [ID_WIDTH-1:0] x);
    logic [ID_WIDTH-1:0] y;
    y = x + 1'b1;
    if (y == '0) y = {{(ID_WIDTH-1){1'b0}}, 1'b1};
    return y;
  endfunction

  sld_pkg::state_t state, state_next;

  // tables
  logic [SW-1:0]        tsong  [TRACKS];
  logic [PW-1:0]        tpar   [TRACKS];
  logic [DW-1:0]        depth  [SONGS];
  logic signed [15:0]   cnt    [SONGS];
  logic                 idv    [NSLOT];
  logic [ID_WIDTH-1:0]  nid;

  // memories
  logic [ID_WIDTH-1:0]  tags [DATA_DEPTH];
  logic [ID_WIDTH-1:0]  ids  [NSLOT];
  logic [ID_WIDTH-1:0]  tag_q, id_q;
  logic                 idv_q;

  // latched command
  sld_pkg::cmd_t        c_cmd;
  logic [TW-1:0]        c_t;
  logic                 c_tok;
  logic [SW-1:0]        c_song;
  logic signed [4:0]    c_par;
  logic [11:0]          c_pr;
  logic                 c_skip;
  logic [SW-1:0]        c_s;
  logic [DW-1:0]        c_d;
  logic signed [15:0]   c_cnt;
  logic [PW-1:0]        c_pp;
  logic [ID_WIDTH-1:0]  c_tag;
  logic signed [15:0]   lowest;
  logic [IW-1:0]        i;
  logic [SW-1:0]        js;
  logic [DW-1:0]        j, jd;
  logic [AW-1:0]        clr;

  // shared table read port
  logic                 scan;
  logic [TW-1:0]        rt;
  logic [SW-1:0]        rs;
  logic [DW-1:0]        rd;
  logic signed [15:0]   rc;
  logic [PW-1:0]        rp;
  logic [PW-1:0]        t_plus1;
  logic [LW-1:0]        ids_ra, own_slot;
  logic                 mod_done, i_end;

  // check evaluation
  logic [ID_WIDTH-1:0]  id0, cur, nid_a, fin_id, nid_b;
  logic                 hit;

  assign rt       = scan ? TW'(i) : c_t;
  assign rs       = tsong[rt];
  assign rd       = depth[rs];
  assign rc       = cnt[rs];
  assign rp       = tpar[rt];
  assign t_plus1  = PW'(c_t) + 1'b1;
  assign own_slot = LW'(32'(c_s) * SLOTS + 32'(c_d));
  assign mod_done = !(32'(c_pr) >= DATA_DEPTH);
  assign i_end    = (32'(i) == TRACKS);
  assign clearing = (state == sld_pkg::S_CLEAR);

  always_comb begin
    id0    = idv_q ? id_q : '0;
    cur    = (id0 == '0) ? issue(nid) : id0;
    nid_a  = (id0 == '0) ? issue(nid) : nid;
    hit    = (tag_q == cur) && !c_cnt[15] && (c_cnt < sld_pkg::COUNT_MAX);
    fin_id = hit ? issue(nid_a) : cur;
    nid_b  = hit ? issue(nid_a) : nid_a;
  end

  // outputs of the sequencer
  always_comb begin
    scan   = (state == sld_pkg::S_JT) || (state == sld_pkg::S_COUNT);
    pop    = (state == sld_pkg::S_IDLE) && q.valid;
    ids_ra = (c_cmd == sld_pkg::CMD_JUMP) ? LW'(32'(js) * SLOTS + 32'(j)) : own_slot;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sld_pkg::S_CLEAR: if (clr == AW'(DATA_DEPTH - 1)) state_next = sld_pkg::S_IDLE;
      sld_pkg::S_IDLE:  if (q.valid) state_next = sld_pkg::S_EXEC;
      sld_pkg::S_EXEC: begin
        state_next = sld_pkg::S_IDLE;
        if (c_cmd != sld_pkg::CMD_RESET && c_tok) begin
          priority case (c_cmd)
            sld_pkg::CMD_CHECK: if (!(32'(rd) >= MAX_STACK) && !c_skip)
                                  state_next = sld_pkg::S_MOD;
            sld_pkg::CMD_JUMP:  if (!rc[15]) state_next = sld_pkg::S_MOD;
            sld_pkg::CMD_GET:   state_next = sld_pkg::S_COUNT;
            default:            state_next = sld_pkg::S_IDLE;
          endcase
        end
      end
      sld_pkg::S_MOD:  if (mod_done) state_next = sld_pkg::S_RD;
      sld_pkg::S_RD: begin
        if (c_cmd == sld_pkg::CMD_JUMP && tag_q != '0) state_next = sld_pkg::S_JT;
        else state_next = sld_pkg::S_IDLE;
      end
      sld_pkg::S_JT: begin
        if (i_end) state_next = sld_pkg::S_IDLE;
        else if (TW'(i) != c_t && (rp == c_pp || rp == t_plus1)) state_next = sld_pkg::S_JR;
      end
      sld_pkg::S_JR:  state_next = sld_pkg::S_JC;
      sld_pkg::S_JC: begin
        if (idv_q && id_q == c_tag) state_next = sld_pkg::S_IDLE;
        else if (j == jd) state_next = sld_pkg::S_JT;
        else state_next = sld_pkg::S_JR;
      end
      sld_pkg::S_COUNT: if (i_end) state_next = sld_pkg::S_IDLE;
      default: state_next = sld_pkg::S_IDLE;
    endcase
  end

  // memories: tag memory has the clear sweep on its write port
  always_ff @(posedge clk) begin
    if (state == sld_pkg::S_CLEAR) begin
      tags[clr] <= '0;
    end else if (state == sld_pkg::S_RD && c_cmd == sld_pkg::CMD_CHECK) begin
      tags[AW'(c_pr)] <= fin_id;
    end
    tag_q <= tags[AW'(c_pr)];
  end

  always_ff @(posedge clk) begin
    if (state == sld_pkg::S_EXEC && c_cmd == sld_pkg::CMD_PUSH && c_tok &&
        32'(rd) < MAX_STACK) begin
      ids[LW'(32'(rs) * SLOTS + 32'(rd) + 1)] <= issue(nid);
    end else if (state == sld_pkg::S_RD && c_cmd == sld_pkg::CMD_CHECK) begin
      ids[own_slot] <= fin_id;
    end else if (state == sld_pkg::S_JC && idv_q && id_q == c_tag && c_d != '0) begin
      ids[LW'(32'(c_s) * SLOTS + 32'(j))] <= c_tag;
    end
    id_q  <= ids[ids_ra];
    idv_q <= idv[ids_ra];
  end

  // command fields and scan registers
  always_ff @(posedge clk) begin
    if (pop) begin
      c_cmd  <= q.head.cmd;
      c_t    <= TW'(q.head.track);
      c_tok  <= q.head.track_ok;
      c_song <= SW'(q.head.song);
      c_par  <= q.head.parent;
      c_pr   <= q.head.position;
      c_skip <= q.head.skip;
    end
    unique case (state)
      sld_pkg::S_EXEC: begin
        c_s    <= rs;
        c_d    <= rd;
        c_cnt  <= rc;
        c_pp   <= rp;
        lowest <= rc;
        i      <= '0;
      end
      sld_pkg::S_MOD: if (!mod_done) c_pr <= c_pr - 12'(DATA_DEPTH);
      sld_pkg::S_RD:  c_tag <= tag_q;
      sld_pkg::S_JT: begin
        js <= rs;
        jd <= (32'(rd) > MAX_STACK) ? DW'(MAX_STACK) : rd;
        j  <= '0;
        if (!(TW'(i) != c_t && (rp == c_pp || rp == t_plus1))) i <= i + 1'b1;
      end
      sld_pkg::S_JC: begin
        if (j == jd) i <= i + 1'b1;
        else j <= j + 1'b1;
      end
      sld_pkg::S_COUNT: begin
        if (!i_end) begin
          if (rp == t_plus1 && !rc[15] && rc < lowest) lowest <= rc;
          i <= i + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // tables, ID counter, state and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sld_pkg::S_CLEAR;
      clr   <= '0;
      nid   <= {{(ID_WIDTH-1){1'b0}}, 1'b1};
      done  <= 1'b0;
      loop_count <= '0;
      for (int k = 0; k < TRACKS; k++) begin
        tsong[k] <= '0;
        tpar[k]  <= '0;
      end
      for (int k = 0; k < SONGS; k++) begin
        depth[k] <= '0;
        cnt[k]   <= '0;
      end
      for (int k = 0; k < NSLOT; k++) idv[k] <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == sld_pkg::S_CLEAR) clr <= clr + 1'b1;
      // the end of the clear sweep carries no command
      if (state != sld_pkg::S_IDLE && state != sld_pkg::S_CLEAR &&
          state_next == sld_pkg::S_IDLE) begin
        done       <= 1'b1;
        loop_count <= (c_cmd == sld_pkg::CMD_GET && c_tok) ? lowest : '0;
      end
      unique case (state)
        sld_pkg::S_EXEC: begin
          if (c_cmd == sld_pkg::CMD_RESET) begin
            nid <= issue(nid);
            for (int k = 0; k < TRACKS; k++) begin
              tsong[k] <= '0;
              tpar[k]  <= '0;
            end
            for (int k = 0; k < SONGS; k++) begin
              depth[k] <= '0;
              cnt[k]   <= '0;
            end
            for (int k = 0; k < NSLOT; k++) idv[k] <= 1'b0;
          end else if (c_tok) begin
            unique case (c_cmd)
              sld_pkg::CMD_START: begin
                tsong[c_t]    <= c_song;
                tpar[c_t]     <= (!c_par[4] && 32'(c_par) < TRACKS) ?
                                 PW'(32'(c_par) + 1) : '0;
                depth[c_song] <= '0;
              end
              sld_pkg::CMD_STOP: begin
                cnt[rs]   <= sld_pkg::COUNT_STOPPED;
                tpar[c_t] <= '0;
              end
              sld_pkg::CMD_PUSH: begin
                if (32'(rd) < MAX_STACK) begin
                  depth[rs] <= rd + 1'b1;
                  nid       <= issue(nid);
                  idv[LW'(32'(rs) * SLOTS + 32'(rd) + 1)] <= 1'b1;
                end
              end
              sld_pkg::CMD_POP: begin
                if (rd != '0 && 32'(rd) <= MAX_STACK) depth[rs] <= rd - 1'b1;
              end
              default: ;
            endcase
          end
        end
        sld_pkg::S_RD: begin
          if (c_cmd == sld_pkg::CMD_CHECK) begin
            nid           <= nid_b;
            idv[own_slot] <= 1'b1;
            if (hit) cnt[c_s] <= c_cnt + 16'sd1;
          end
        end
        sld_pkg::S_JC: begin
          if (idv_q && id_q == c_tag) begin
            cnt[c_s] <= sld_pkg::COUNT_SHARED;
            if (c_d != '0) idv[LW'(32'(c_s) * SLOTS + 32'(j))] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/sequence_loop_detector_unit.sv =====
// ----------------------------------------------------------------------------
// sequence_loop_detector_unit
// Loop detector for sequenced tracks: position tagging, ID stacks, counts.
// ----------------------------------------------------------------------------
// After reset the tag memory is swept to zero with busy high. A command is
// taken when start is high and busy is low, and goes into a two-entry queue;
// busy rises only while that queue is full or the sweep runs. One result per
// command appears on loop_count with done/done_res high for one cycle; the
// receiver cannot stall it. Each command is run by one sequencer: start, stop,
// push, pop and reset finish in the execute state; check reduces the position
// by subtracting DATA_DEPTH, then reads and writes the tag and ID memories
// (neither when skipped or the stack is full); get count scans every track;
// jump reduces the position, then scans the tracks and, for each matching
// track, reads the ID stack memory one entry at a time.
module sequence_loop_detector_unit #(
  parameter int DATA_DEPTH = sld_pkg::DEF_DATA_DEPTH,
  parameter int SONGS      = sld_pkg::DEF_SONGS,
  parameter int TRACKS     = sld_pkg::DEF_TRACKS,
  parameter int MAX_STACK  = sld_pkg::DEF_MAX_STACK,
  parameter int ID_WIDTH   = sld_pkg::DEF_ID_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd,
  input  logic [3:0]         track,
  input  logic signed [4:0]  parent,
  input  logic [3:0]         song,
  input  logic [11:0]        position,
  input  logic               skip_check,
  output logic               done,
  output logic signed [15:0] loop_count,
  output logic               done_res
);

  sld_pkg::sld_queue_t q;
  logic pop, clearing;

  sld_front #(
    .SONGS  (SONGS),
    .TRACKS (TRACKS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .track      (track),
    .parent     (parent),
    .song       (song),
    .position   (position),
    .skip_check (skip_check),
    .clearing   (clearing),
    .pop        (pop),
    .busy       (busy),
    .q          (q)
  );

  sld_back #(
    .DATA_DEPTH (DATA_DEPTH),
    .SONGS      (SONGS),
    .TRACKS     (TRACKS),
    .MAX_STACK  (MAX_STACK),
    .ID_WIDTH   (ID_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q          (q),
    .pop        (pop),
    .clearing   (clearing),
    .loop_count (loop_count),
    .done       (done)
  );

  assign done_res = done;

endmodule
